FILE: src/ptzc_pkg.sv
package ptzc_pkg;

    // one request on the input channel
    typedef struct packed {
        logic        kind;
        logic [5:0]  command;
        logic [9:0]  camera_number;
        logic [5:0]  camera_slot;
        logic [15:0] value_low;
        logic [15:0] value_high;
    } t_cmd_req;

    // one seven-byte frame plus its flags
    typedef struct packed {
        logic [7:0] header_ones;
        logic [7:0] hundreds_tens;
        logic [7:0] menu_byte;
        logic [2:0] mode_byte;
        logic [7:0] control_byte;
        logic [7:0] data_byte;
        logic [7:0] parity_byte;
        logic       repeat_allowed;
        logic       last_frame;
    } t_frame;

    localparam logic KIND_CAMERA = 1'b0;
    localparam logic KIND_MENU   = 1'b1;

    localparam logic [5:0] CMD_PAN_LEFT    = 6'd0;
    localparam logic [5:0] CMD_PAN_RIGHT   = 6'd1;
    localparam logic [5:0] CMD_PAN_STOP    = 6'd2;
    localparam logic [5:0] CMD_TILT_UP     = 6'd3;
    localparam logic [5:0] CMD_TILT_DOWN   = 6'd4;
    localparam logic [5:0] CMD_TILT_STOP   = 6'd5;
    localparam logic [5:0] CMD_ZOOM_IN     = 6'd6;
    localparam logic [5:0] CMD_ZOOM_OUT    = 6'd7;
    localparam logic [5:0] CMD_ZOOM_STOP   = 6'd8;
    localparam logic [5:0] CMD_FOCUS_NEAR  = 6'd9;
    localparam logic [5:0] CMD_FOCUS_FAR   = 6'd10;
    localparam logic [5:0] CMD_FOCUS_STOP  = 6'd11;
    localparam logic [5:0] CMD_FOCUS_AUTO  = 6'd12;
    localparam logic [5:0] CMD_IRIS_STOP   = 6'd15;
    localparam logic [5:0] CMD_MOVE_LU     = 6'd17;
    localparam logic [5:0] CMD_MOVE_RU     = 6'd18;
    localparam logic [5:0] CMD_MOVE_LD     = 6'd19;
    localparam logic [5:0] CMD_MOVE_RD     = 6'd20;
    localparam logic [5:0] CMD_MOVE_STOP   = 6'd21;
    localparam logic [5:0] CMD_PRESET_BASE = 6'd21;
    localparam logic [5:0] CMD_HOME        = 6'd31;
    localparam logic [5:0] CMD_AUX         = 6'd32;

    localparam logic [2:0] MODE_MENU    = 3'd0;
    localparam logic [2:0] MODE_PRESET  = 3'd1;
    localparam logic [2:0] MODE_MANUAL  = 3'd2;
    localparam logic [2:0] MODE_AUX_OUT = 3'd4;

    localparam logic [2:0] MENU_ON    = 3'd0;
    localparam logic [2:0] MENU_OFF   = 3'd1;
    localparam logic [2:0] MENU_ENTER = 3'd2;
    localparam logic [2:0] MENU_CLEAR = 3'd3;
    localparam logic [2:0] MENU_UP    = 3'd4;
    localparam logic [2:0] MENU_RIGHT = 3'd5;
    localparam logic [2:0] MENU_DOWN  = 3'd6;
    localparam logic [2:0] MENU_LEFT  = 3'd7;

    localparam logic [7:0] MENU_BYTE_ON    = 8'h08;
    localparam logic [7:0] MENU_BYTE_ENTER = 8'h18;
    localparam logic [7:0] MENU_BYTE_CLEAR = 8'h28;
    localparam logic [7:0] MENU_BYTE_HORZ  = 8'h48;
    localparam logic [7:0] MENU_BYTE_VERT  = 8'h88;
    localparam logic [7:0] HEADER_BASE     = 8'hF0;
    localparam logic [7:0] PARITY_SEED     = 8'hFF;
    localparam logic [7:0] PRESET_STORE    = 8'h40;
    localparam logic [7:0] HOME_POSITION   = 8'hFF;

    // speed min(10,v) quantized as (3v+3)/10
    function automatic logic [1:0] quant_speed(input logic [15:0] v);
        logic [1:0] q;
        if (v >= 16'd9) begin
            q = 2'd3;
        end else if (v >= 16'd6) begin
            q = 2'd2;
        end else if (v >= 16'd3) begin
            q = 2'd1;
        end else begin
            q = 2'd0;
        end
        return q;
    endfunction

    function automatic logic [7:0] menu_first(input logic [2:0] code);
        logic [7:0] b;
        unique case (code)
            MENU_ON:               b = MENU_BYTE_ON;
            MENU_OFF:              b = 8'h00;
            MENU_ENTER:            b = MENU_BYTE_ENTER;
            MENU_CLEAR:            b = MENU_BYTE_CLEAR;
            MENU_UP, MENU_RIGHT:   b = MENU_BYTE_HORZ;
            MENU_DOWN, MENU_LEFT:  b = MENU_BYTE_VERT;
            default:               b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: src/ptz_camera_command_frame_encoder.sv
// A request is registered in the encode stage, which builds its frames into the output
// register, at 1 request per cycle for camera commands while the output is not stalled;
// a menu request with a second frame holds the stage for both frames, and one frame leaves
// the output register per cycle unless stalled. Aux-out read-modify-write goes through one
// RAM read port with registered data. Reset (synchronous, active low) empties the pipeline
// and marks every aux slot as zero through per-slot valid bits; no clearing pass is needed.
module ptz_camera_command_frame_encoder
    import ptzc_pkg::*;
#(
    parameter int CAMERA_SLOTS = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_cmd_req i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_frame   o_out_data
);

    // Only 64 slot codes are reachable through a 6-bit slot field.
    localparam int DEPTH = (CAMERA_SLOTS < 64) ? CAMERA_SLOTS : 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ---------------------------------------------------------------
    // Encode stage registers: the request, a phase bit for the second
    // menu frame, and aux forwarding from a same-edge write.
    // ---------------------------------------------------------------
    logic       r_s1_vld;
    t_cmd_req   r_s1;
    logic       r_s1_phase;
    logic       r_fwd_hit;
    logic [1:0] r_fwd_bits;
    logic       r_old_vld;
    logic [DEPTH-1:0] r_aux_vld;

    logic       r_out_vld;
    t_frame     r_out;

    logic       w_accept;
    logic       w_out_free;
    logic       w_has_frame;
    logic       w_last;
    logic       w_emit;
    logic       w_done;
    logic       w_cam_ok;
    logic       w_s1_slot_ok;
    logic       w_in_slot_ok;
    logic [AW-1:0] w_s1_idx;
    logic [AW-1:0] w_in_idx;
    logic       w_wr_en;
    logic [1:0] w_ram_rd;
    logic [1:0] w_old_bits;
    logic [1:0] w_mask;
    logic [1:0] w_new_bits;
    logic [1:0] w_aux_bits;

    // decimal digits by reciprocal multiplication (exact for 0..1023)
    logic [15:0] w_mul41;
    logic [17:0] w_mul205;
    logic [3:0]  w_hund;
    logic [6:0]  w_q10;
    logic [9:0]  w_ones_full;
    logic [6:0]  w_tens_full;

    logic        w_menu_small;
    logic        w_menu_second;
    logic [1:0]  w_sx;
    logic [1:0]  w_sy;
    logic [5:0]  w_pos;

    t_frame      n_frame;

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_emit     = w_has_frame && w_out_free;
    // The stage frees up when its request yields nothing or its last frame leaves.
    assign w_done     = r_s1_vld && (!w_has_frame || (w_out_free && w_last));
    assign o_in_stall = r_s1_vld && !w_done;
    assign w_accept   = i_in_valid && !o_in_stall;

    // ---------------------------------------------------------------
    // Camera number and request classification
    // ---------------------------------------------------------------
    assign w_cam_ok    = (r_s1.camera_number != 10'd0) && (r_s1.camera_number <= 10'd999);
    assign w_has_frame = r_s1_vld && w_cam_ok &&
                         ((r_s1.kind == KIND_MENU) || (r_s1.command <= CMD_AUX));

    assign w_mul41     = 16'(r_s1.camera_number) * 16'd41;
    assign w_mul205    = 18'(r_s1.camera_number) * 18'd205;
    assign w_hund      = w_mul41[15:12];
    assign w_q10       = w_mul205[17:11];
    assign w_ones_full = r_s1.camera_number - 10'(w_q10) * 10'd10;
    assign w_tens_full = w_q10 - 7'(w_hund) * 7'd10;

    // Menu value is the 32-bit word value_high:value_low.
    assign w_menu_small  = (r_s1.value_high == 16'd0) && (r_s1.value_low[15:3] == 13'd0);
    assign w_menu_second = w_menu_small && (r_s1.value_low[2:0] != MENU_OFF);
    assign w_last        = (r_s1.kind == KIND_CAMERA) || r_s1_phase || !w_menu_second;

    assign w_sx  = quant_speed(r_s1.value_low);
    assign w_sy  = quant_speed((r_s1.value_high != 16'd0) ? r_s1.value_high
                                                           : r_s1.value_low);
    assign w_pos = r_s1.command - CMD_PRESET_BASE;

    // ---------------------------------------------------------------
    // Aux-out bits: RAM with per-slot valid bits; an unwritten slot reads zero.
    // ---------------------------------------------------------------
    assign w_s1_slot_ok = 32'(r_s1.camera_slot) < CAMERA_SLOTS;
    assign w_in_slot_ok = 32'(i_in_data.camera_slot) < CAMERA_SLOTS;
    assign w_s1_idx     = w_s1_slot_ok ? AW'(r_s1.camera_slot) : '0;
    assign w_in_idx     = w_in_slot_ok ? AW'(i_in_data.camera_slot) : '0;

    assign w_old_bits = r_fwd_hit ? r_fwd_bits : (r_old_vld ? w_ram_rd : 2'b00);
    assign w_mask     = (r_s1.value_low == 16'd1) ? 2'b01 :
                        (r_s1.value_low == 16'd2) ? 2'b10 : 2'b00;
    assign w_new_bits = (r_s1.value_high != 16'd0) ? (w_old_bits | w_mask)
                                                   : (w_old_bits & ~w_mask);
    assign w_aux_bits = w_s1_slot_ok ? w_new_bits : 2'b00;

    // write back when the aux frame leaves the stage
    assign w_wr_en = w_done && w_has_frame && (r_s1.kind == KIND_CAMERA) &&
                     (r_s1.command == CMD_AUX) && w_s1_slot_ok;

    ptzc_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_aux_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_s1_idx),
        .i_wr_data (w_new_bits),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_in_idx),
        .o_rd_data (w_ram_rd)
    );

    // ---------------------------------------------------------------
    // Frame build
    // ---------------------------------------------------------------
    always_comb begin
        n_frame                = '0;
        n_frame.header_ones    = HEADER_BASE | {4'h0, w_ones_full[3:0]};
        n_frame.hundreds_tens  = {w_hund, w_tens_full[3:0]};
        n_frame.last_frame     = w_last;

        if (r_s1.kind == KIND_MENU) begin
            n_frame.mode_byte = MODE_MENU;
            if (r_s1_phase) begin
                n_frame.menu_byte      = MENU_BYTE_ON;
                n_frame.repeat_allowed = 1'b1;
            end else begin
                n_frame.menu_byte = w_menu_small ? menu_first(r_s1.value_low[2:0]) : 8'h00;
            end
        end else if (r_s1.command <= CMD_MOVE_STOP) begin
            n_frame.mode_byte      = MODE_MANUAL;
            n_frame.repeat_allowed = 1'b1;
            unique case (r_s1.command)
                CMD_PAN_LEFT: begin
                    n_frame.control_byte = 8'h08;
                    n_frame.data_byte    = {4'h0, w_sx, 2'b00};
                end
                CMD_PAN_RIGHT: begin
                    n_frame.control_byte = 8'h04;
                    n_frame.data_byte    = {4'h0, w_sx, 2'b00};
                end
                CMD_TILT_UP: begin
                    n_frame.control_byte = 8'h01;
                    n_frame.data_byte    = {6'h00, w_sy};
                end
                CMD_TILT_DOWN: begin
                    n_frame.control_byte = 8'h02;
                    n_frame.data_byte    = {6'h00, w_sy};
                end
                CMD_ZOOM_IN: begin
                    n_frame.control_byte = 8'h10;
                    n_frame.data_byte    = {2'b00, w_sx, 4'h0};
                end
                CMD_ZOOM_OUT: begin
                    n_frame.control_byte = 8'h20;
                    n_frame.data_byte    = {2'b00, w_sx, 4'h0};
                end
                CMD_FOCUS_NEAR: begin
                    n_frame.control_byte = 8'h80;
                    n_frame.data_byte    = {w_sx, 6'h00};
                end
                CMD_FOCUS_FAR: begin
                    n_frame.control_byte = 8'h40;
                    n_frame.data_byte    = {w_sx, 6'h00};
                end
                CMD_FOCUS_AUTO: begin
                    n_frame.control_byte = 8'hC0;
                    n_frame.data_byte    = {w_sx, 6'h00};
                end
                CMD_MOVE_LU: begin
                    n_frame.control_byte = 8'h09;
                    n_frame.data_byte    = {4'h0, w_sx, w_sy};
                end
                CMD_MOVE_RU: begin
                    n_frame.control_byte = 8'h05;
                    n_frame.data_byte    = {4'h0, w_sx, w_sy};
                end
                CMD_MOVE_LD: begin
                    n_frame.control_byte = 8'h0A;
                    n_frame.data_byte    = {4'h0, w_sx, w_sy};
                end
                CMD_MOVE_RD: begin
                    n_frame.control_byte = 8'h06;
                    n_frame.data_byte    = {4'h0, w_sx, w_sy};
                end
                CMD_PAN_STOP, CMD_TILT_STOP, CMD_ZOOM_STOP,
                CMD_FOCUS_STOP, CMD_IRIS_STOP, CMD_MOVE_STOP: begin
                    n_frame.repeat_allowed = 1'b0;
                end
                default: begin
                    // iris open, close, auto: empty repeatable frame
                end
            endcase
        end else if (r_s1.command <= CMD_HOME) begin
            n_frame.mode_byte = MODE_PRESET;
            if (r_s1.command == CMD_HOME) begin
                n_frame.control_byte = {2'b00, HOME_POSITION[5:0]};
                n_frame.data_byte    = {6'h00, HOME_POSITION[7:6]};
            end else begin
                n_frame.control_byte = {2'b00, w_pos};
            end
            if ((r_s1.value_low | r_s1.value_high) != 16'd0) begin
                n_frame.control_byte = n_frame.control_byte | PRESET_STORE;
            end
        end else begin
            // aux out: each pair of control bits is 10 when off, 01 when on
            n_frame.mode_byte    = MODE_AUX_OUT;
            n_frame.control_byte = {4'h0,
                                    w_aux_bits[0] ? 2'b01 : 2'b10,
                                    w_aux_bits[1] ? 2'b01 : 2'b10};
        end

        n_frame.parity_byte = PARITY_SEED ^ n_frame.header_ones ^ n_frame.hundreds_tens ^
                              n_frame.menu_byte ^ {5'b00000, n_frame.mode_byte} ^
                              n_frame.control_byte ^ n_frame.data_byte;
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s1_phase <= 1'b0;
            r_out_vld  <= 1'b0;
            r_aux_vld  <= '0;
        end else begin
            if (w_accept) begin
                r_s1_vld   <= 1'b1;
                r_s1_phase <= 1'b0;
            end else begin
                if (w_done) begin
                    r_s1_vld <= 1'b0;
                end
                if (w_emit && !w_last) begin
                    r_s1_phase <= 1'b1;
                end
            end

            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            if (w_wr_en) begin
                r_aux_vld[w_s1_idx] <= 1'b1;
            end
        end
    end

    // payload and read-side bookkeeping, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1       <= i_in_data;
            r_old_vld  <= r_aux_vld[w_in_idx];
            // the RAM returns pre-write data when a write lands on the same edge
            r_fwd_hit  <= w_wr_en && (r_s1.camera_slot == i_in_data.camera_slot);
            r_fwd_bits <= w_new_bits;
        end
        if (w_emit) begin
            r_out <= n_frame;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

FILE: src/ptzc_ram.sv
module ptzc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ptzc_pkg::*;

    // ------------------------------------------------------------------
    // Local codes the package does not name
    // ------------------------------------------------------------------
    localparam int AUX_SLOTS   = 64;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_SPEED   = 10;
    localparam int PRINT_LIMIT = 40;

    localparam logic [5:0] CMD_IRIS_OPEN  = 6'd13;
    localparam logic [5:0] CMD_IRIS_CLOSE = 6'd14;
    localparam logic [5:0] CMD_IRIS_AUTO  = 6'd16;
    localparam logic [5:0] CMD_LAST       = 6'd63;

    // manual mode function bits; diagonal moves combine pan and tilt bits
    localparam logic [7:0] CTL_TILT_UP    = 8'h01;
    localparam logic [7:0] CTL_TILT_DOWN  = 8'h02;
    localparam logic [7:0] CTL_PAN_RIGHT  = 8'h04;
    localparam logic [7:0] CTL_PAN_LEFT   = 8'h08;
    localparam logic [7:0] CTL_ZOOM_IN    = 8'h10;
    localparam logic [7:0] CTL_ZOOM_OUT   = 8'h20;
    localparam logic [7:0] CTL_FOCUS_FAR  = 8'h40;
    localparam logic [7:0] CTL_FOCUS_NEAR = 8'h80;
    localparam logic [7:0] CTL_FOCUS_AUTO = 8'hC0;

    // aux-out control byte: both outputs off by default, on-bit replaces off-bit
    localparam logic [7:0]  AUX_CTL_BASE = 8'h0A;
    localparam logic [7:0]  AUX1_OFF     = 8'h08;
    localparam logic [7:0]  AUX1_ON      = 8'h04;
    localparam logic [7:0]  AUX2_OFF     = 8'h02;
    localparam logic [7:0]  AUX2_ON      = 8'h01;
    localparam logic [15:0] AUX_OUT_1    = 16'd1;
    localparam logic [15:0] AUX_OUT_2    = 16'd2;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_cmd_req i_in_data;
    logic     o_out_valid;
    logic     i_out_stall;
    t_frame   o_out_data;

    ptz_camera_command_frame_encoder #(
        .CAMERA_SLOTS(AUX_SLOTS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // ------------------------------------------------------------------
    // Scoreboard state
    // ------------------------------------------------------------------
    t_frame     pending_frames[$];      // frames owed by accepted requests, in order
    logic [1:0] aux_state[AUX_SLOTS];   // mirror of the per-slot aux output bits
    int         error_count = 0;
    int         cycle_count = 0;
    bit         in_idle_on  = 1'b1;     // sender inserts gaps
    bit         out_idle_on = 1'b1;     // receiver inserts stalls

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------

    // speed clamped to 10, then scaled to 0..3 with rounding as (3v+3)/10
    function automatic logic [1:0] speed_code(input logic [15:0] v);
        int unsigned c;
        c = (v > 16'(MAX_SPEED)) ? MAX_SPEED : v;
        return 2'((3 * c + 3) / 10);
    endfunction

    function automatic void push_frame(input logic [7:0] h1, input logic [7:0] h2,
                                       input logic [7:0] menu, input logic [2:0] mode,
                                       input logic [7:0] ctl, input logic [7:0] dat,
                                       input logic rep, input logic last);
        t_frame f;
        f.header_ones    = h1;
        f.hundreds_tens  = h2;
        f.menu_byte      = menu;
        f.mode_byte      = mode;
        f.control_byte   = ctl;
        f.data_byte      = dat;
        f.parity_byte    = PARITY_SEED ^ h1 ^ h2 ^ menu ^ {5'b0, mode} ^ ctl ^ dat;
        f.repeat_allowed = rep;
        f.last_frame     = last;
        pending_frames.push_back(f);
    endfunction

    // Works out the frames one accepted request causes and updates the aux mirror.
    function automatic void encode_request(input t_cmd_req req);
        int unsigned cam;
        logic [7:0]  h1, h2, ctl, dat, pos, menu;
        logic [2:0]  mode;
        logic [1:0]  sx, sy, mask, bits;
        logic [31:0] menu_val;
        logic        rep, second;
        cam = req.camera_number;
        // out-of-range address: nothing sent, nothing stored
        if (cam < 1 || cam > 999) begin
            return;
        end
        h1 = HEADER_BASE + 8'(cam % 10);
        h2 = {4'(cam / 100), 4'((cam / 10) % 10)};

        if (req.kind == KIND_MENU) begin
            menu_val = {req.value_high, req.value_low};
            menu = 8'h00;
            second = 1'b0;
            if (menu_val < 32'd8) begin
                second = (menu_val[2:0] != MENU_OFF);
                case (menu_val[2:0])
                    MENU_ON:                menu = MENU_BYTE_ON;
                    MENU_ENTER:             menu = MENU_BYTE_ENTER;
                    MENU_CLEAR:             menu = MENU_BYTE_CLEAR;
                    MENU_UP, MENU_RIGHT:    menu = MENU_BYTE_HORZ;
                    MENU_DOWN, MENU_LEFT:   menu = MENU_BYTE_VERT;
                    default:                menu = 8'h00;
                endcase
            end
            push_frame(h1, h2, menu, MODE_MENU, 8'h00, 8'h00, 1'b0, !second);
            // repeatable follow-up carries the same byte as menu-on
            if (second) begin
                push_frame(h1, h2, MENU_BYTE_ON, MODE_MENU, 8'h00, 8'h00, 1'b1, 1'b1);
            end
            return;
        end

        sx   = speed_code(req.value_low);
        sy   = speed_code((req.value_high != 16'd0) ? req.value_high : req.value_low);
        ctl  = 8'h00;
        dat  = 8'h00;
        rep  = 1'b0;
        mode = MODE_MANUAL;
        if (req.command <= CMD_MOVE_STOP) begin
            rep = 1'b1;
            case (req.command)
                CMD_PAN_LEFT: begin
                    ctl = CTL_PAN_LEFT;
                    dat = {4'b0, sx, 2'b0};
                end
                CMD_PAN_RIGHT: begin
                    ctl = CTL_PAN_RIGHT;
                    dat = {4'b0, sx, 2'b0};
                end
                CMD_TILT_UP: begin
                    ctl = CTL_TILT_UP;
                    dat = {6'b0, sy};
                end
                CMD_TILT_DOWN: begin
                    ctl = CTL_TILT_DOWN;
                    dat = {6'b0, sy};
                end
                CMD_ZOOM_IN: begin
                    ctl = CTL_ZOOM_IN;
                    dat = {2'b0, sx, 4'b0};
                end
                CMD_ZOOM_OUT: begin
                    ctl = CTL_ZOOM_OUT;
                    dat = {2'b0, sx, 4'b0};
                end
                CMD_FOCUS_NEAR: begin
                    ctl = CTL_FOCUS_NEAR;
                    dat = {sx, 6'b0};
                end
                CMD_FOCUS_FAR: begin
                    ctl = CTL_FOCUS_FAR;
                    dat = {sx, 6'b0};
                end
                CMD_FOCUS_AUTO: begin
                    ctl = CTL_FOCUS_AUTO;
                    dat = {sx, 6'b0};
                end
                CMD_MOVE_LU: begin
                    ctl = CTL_PAN_LEFT | CTL_TILT_UP;
                    dat = {4'b0, sx, sy};
                end
                CMD_MOVE_RU: begin
                    ctl = CTL_PAN_RIGHT | CTL_TILT_UP;
                    dat = {4'b0, sx, sy};
                end
                CMD_MOVE_LD: begin
                    ctl = CTL_PAN_LEFT | CTL_TILT_DOWN;
                    dat = {4'b0, sx, sy};
                end
                CMD_MOVE_RD: begin
                    ctl = CTL_PAN_RIGHT | CTL_TILT_DOWN;
                    dat = {4'b0, sx, sy};
                end
                CMD_PAN_STOP, CMD_TILT_STOP, CMD_ZOOM_STOP, CMD_FOCUS_STOP,
                CMD_IRIS_STOP, CMD_MOVE_STOP: begin
                    rep = 1'b0;
                end
                // iris open / close / auto: empty repeatable frame
                default: ;
            endcase
        end else if (req.command <= CMD_HOME) begin
            mode = MODE_PRESET;
            pos  = (req.command == CMD_HOME) ? HOME_POSITION
                                              : 8'(req.command - CMD_PRESET_BASE);
            ctl  = {2'b00, pos[5:0]};
            if ((req.value_low | req.value_high) != 16'd0) begin
                ctl = ctl | PRESET_STORE;
            end
            dat = {6'b0, pos[7:6]};
        end else if (req.command == CMD_AUX) begin
            mode = MODE_AUX_OUT;
            // output numbers other than 1 and 2 leave the bits alone
            mask = (req.value_low == AUX_OUT_1) ? 2'b01 :
                   (req.value_low == AUX_OUT_2) ? 2'b10 : 2'b00;
            bits = 2'b00;
            if (int'(req.camera_slot) < AUX_SLOTS) begin
                if (req.value_high != 16'd0) begin
                    aux_state[req.camera_slot] = aux_state[req.camera_slot] | mask;
                end else begin
                    aux_state[req.camera_slot] = aux_state[req.camera_slot] & ~mask;
                end
                bits = aux_state[req.camera_slot];
            end
            ctl = AUX_CTL_BASE;
            if (bits[0]) begin
                ctl = (ctl & ~AUX1_OFF) | AUX1_ON;
            end
            if (bits[1]) begin
                ctl = (ctl & ~AUX2_OFF) | AUX2_ON;
            end
        end else begin
            return;
        end
        push_frame(h1, h2, 8'h00, mode, ctl, dat, rep, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
        end
    endtask

    // compares each accepted frame against the oldest owed one
    always @(posedge i_clk) begin
        t_frame want;
        if (i_rst_n) begin
            if ($isunknown(o_out_valid)) begin
                report_mismatch("o_out_valid unknown", 32'd0, 32'd0);
            end else if (o_out_valid && !i_out_stall) begin
                if (pending_frames.size() == 0) begin
                    report_mismatch("frame with none owed, header", o_out_data.header_ones,
                                    32'd0);
                end else begin
                    want = pending_frames.pop_front();
                    if (o_out_data.header_ones !== want.header_ones)
                        report_mismatch("header_ones", o_out_data.header_ones,
                                        want.header_ones);
                    if (o_out_data.hundreds_tens !== want.hundreds_tens)
                        report_mismatch("hundreds_tens", o_out_data.hundreds_tens,
                                        want.hundreds_tens);
                    if (o_out_data.menu_byte !== want.menu_byte)
                        report_mismatch("menu_byte", o_out_data.menu_byte, want.menu_byte);
                    if (o_out_data.mode_byte !== want.mode_byte)
                        report_mismatch("mode_byte", o_out_data.mode_byte, want.mode_byte);
                    if (o_out_data.control_byte !== want.control_byte)
                        report_mismatch("control_byte", o_out_data.control_byte,
                                        want.control_byte);
                    if (o_out_data.data_byte !== want.data_byte)
                        report_mismatch("data_byte", o_out_data.data_byte, want.data_byte);
                    if (o_out_data.parity_byte !== want.parity_byte)
                        report_mismatch("parity_byte", o_out_data.parity_byte,
                                        want.parity_byte);
                    if (o_out_data.repeat_allowed !== want.repeat_allowed)
                        report_mismatch("repeat_allowed", o_out_data.repeat_allowed,
                                        want.repeat_allowed);
                    if (o_out_data.last_frame !== want.last_frame)
                        report_mismatch("last_frame", o_out_data.last_frame,
                                        want.last_frame);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Idling
    // ------------------------------------------------------------------

    // mostly short idles, now and then a long one
    function automatic int pick_idle_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // receiver back-pressure, changed on the falling edge
    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && out_idle_on && $urandom_range(0, 3) == 0) begin
                stall_left = pick_idle_len();
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------

    // Presents one request from a falling edge and holds it until accepted.
    // Valid stays high afterwards; the drain task, or a gap in the next call, lowers it.
    task automatic send_request(input t_cmd_req req);
        int gap;
        gap = (in_idle_on && $urandom_range(0, 2) == 0) ? pick_idle_len() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        encode_request(req);
    endtask

    // drop valid and wait until every owed frame has come out
    task automatic wait_for_frames();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_cmd_req make_request(input logic kind, input logic [5:0] cmd,
                                              input logic [9:0] cam, input logic [5:0] slot,
                                              input logic [15:0] lo, input logic [15:0] hi);
        t_cmd_req req;
        req.kind          = kind;
        req.command       = cmd;
        req.camera_number = cam;
        req.camera_slot   = slot;
        req.value_low     = lo;
        req.value_high    = hi;
        return req;
    endfunction

    // broad random mix: mostly valid cameras and handled commands, speeds near the
    // quantizer steps, some full-range noise
    function automatic t_cmd_req random_request();
        t_cmd_req    req;
        int unsigned r;
        req.kind        = ($urandom_range(0, 99) < 20) ? KIND_MENU : KIND_CAMERA;
        req.command     = 6'($urandom());
        req.camera_slot = 6'($urandom());
        r = $urandom_range(0, 99);
        if (r < 85) begin
            req.camera_number = 10'($urandom_range(1, 999));
        end else if (r < 90) begin
            req.camera_number = 10'd0;
        end else begin
            req.camera_number = 10'($urandom_range(1000, 1023));
        end
        if (req.kind == KIND_MENU) begin
            r = $urandom_range(0, 99);
            req.value_high = (r < 90) ? 16'd0 : 16'($urandom());
            req.value_low  = (r < 80) ? 16'($urandom_range(0, 7)) :
                             (r < 90) ? 16'($urandom_range(0, 15)) : 16'($urandom());
        end else begin
            r = $urandom_range(0, 99);
            req.command = (r < 80) ? 6'($urandom_range(0, 32)) :
                          (r < 90) ? CMD_AUX : 6'($urandom_range(33, 63));
            r = $urandom_range(0, 99);
            req.value_low  = (r < 50) ? 16'($urandom_range(0, 12)) :
                             (r < 75) ? 16'($urandom_range(0, 3)) : 16'($urandom());
            r = $urandom_range(0, 99);
            req.value_high = (r < 50) ? 16'd0 :
                             (r < 75) ? 16'($urandom_range(0, 12)) : 16'($urandom());
        end
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // every camera command code in turn, first unhandled code included; speeds at 0,
    // a step edge, the clamp and full scale; speed y both given and inherited
    task automatic test_camera_commands();
        logic [15:0] lo, hi;
        logic [9:0]  cam;
        for (int c = 0; c <= int'(CMD_AUX) + 1; c++) begin
            lo  = (c % 4 == 0) ? 16'd0 : (c % 4 == 1) ? 16'd3 :
                  (c % 4 == 2) ? 16'd10 : 16'hFFFF;
            hi  = (c % 3 == 0) ? 16'd0 : (c % 3 == 1) ? 16'd6 : 16'hFFFF;
            cam = (c % 3 == 0) ? 10'd1 : (c % 3 == 1) ? 10'd999 : 10'(100 + c * 25);
            send_request(make_request(KIND_CAMERA, 6'(c), cam, 6'(c), lo, hi));
        end
        send_request(make_request(KIND_CAMERA, CMD_IRIS_OPEN, 10'd5, 6'd0, 16'd9, 16'd0));
        send_request(make_request(KIND_CAMERA, CMD_IRIS_CLOSE, 10'd5, 6'd0, 16'd0, 16'd0));
        send_request(make_request(KIND_CAMERA, CMD_IRIS_AUTO, 10'd5, 6'd0, 16'd2, 16'd8));
        send_request(make_request(KIND_CAMERA, CMD_HOME, 10'd42, 6'd0, 16'd0, 16'd0));
        wait_for_frames();
    endtask

    // each menu code, then codes that match nothing (incl. high half set)
    task automatic test_menu_requests();
        for (int m = 0; m < 8; m++) begin
            send_request(make_request(KIND_MENU, 6'($urandom()), 10'(1 + m * 130),
                                      6'($urandom()), 16'(m), 16'd0));
        end
        send_request(make_request(KIND_MENU, CMD_PAN_LEFT, 10'd77, 6'd0, 16'd8, 16'd0));
        send_request(make_request(KIND_MENU, CMD_AUX, 10'd77, 6'd0, 16'd0, 16'd1));
        send_request(make_request(KIND_MENU, CMD_LAST, 10'd999, 6'd63, 16'hFFFF, 16'hFFFF));
        wait_for_frames();
    endtask

    // camera numbers outside 1..999 and unhandled commands give no frame
    task automatic test_address_limits();
        send_request(make_request(KIND_CAMERA, CMD_PAN_LEFT, 10'd0, 6'd0, 16'd5, 16'd0));
        send_request(make_request(KIND_CAMERA, CMD_AUX, 10'd1000, 6'd3, 16'd1, 16'd1));
        send_request(make_request(KIND_MENU, CMD_PAN_STOP, 10'd1023, 6'd63, 16'd0, 16'd0));
        send_request(make_request(KIND_CAMERA, CMD_LAST, 10'd909, 6'd0, 16'd1, 16'd1));
        send_request(make_request(KIND_CAMERA, CMD_TILT_UP, 10'd100, 6'd0, 16'd7, 16'd0));
        wait_for_frames();
    endtask

    // aux bits set, cleared and left alone per slot; then a random run on a few
    // slots so the stored bits build up
    task automatic test_aux_outputs();
        t_cmd_req    req;
        int unsigned r;
        send_request(make_request(KIND_CAMERA, CMD_AUX, 10'd12, 6'd0, AUX_OUT_1, 16'd1));
        send_request(make_request(KIND_CAMERA, CMD_AUX, 10'd12, 6'd0, AUX_OUT_2, 16'hFFFF));
        send_request(make_request(KIND_CAMERA, CMD_AUX, 10'd12, 6'd0, 16'd3, 16'd1));
        send_request(make_request(KIND_CAMERA, CMD_AUX, 10'd12, 6'd0, AUX_OUT_1, 16'd0));
        send_request(make_request(KIND_CAMERA, CMD_AUX, 10'd12, 6'd63, AUX_OUT_2, 16'd1));
        send_request(make_request(KIND_CAMERA, CMD_AUX, 10'd12, 6'd63, 16'd0, 16'd0));
        for (int n = 0; n < 100; n++) begin
            req = random_request();
            r = $urandom_range(0, 3);
            req.kind        = KIND_CAMERA;
            req.command     = CMD_AUX;
            req.camera_slot = (r < 2) ? 6'(r) : 6'(60 + r);
            req.value_low   = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 3))
                                                         : 16'($urandom());
            send_request(req);
        end
        wait_for_frames();
    endtask

    // main random run; halfway the sender holds off until the output drains
    task automatic test_random_mix();
        for (int n = 0; n < 400; n++) begin
            send_request(random_request());
            if (n == 200) begin
                wait_for_frames();
            end
        end
        wait_for_frames();
    endtask

    // no gaps and no stalls: full-rate requests with menu pairs mixed in
    task automatic test_back_to_back();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        for (int n = 0; n < 100; n++) begin
            send_request(random_request());
        end
        wait_for_frames();
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        foreach (aux_state[k]) begin
            aux_state[k] = 2'b00;
        end
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_camera_commands();
        test_menu_requests();
        test_address_limits();
        test_aux_outputs();
        test_random_mix();
        test_back_to_back();

        wait_for_frames();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
